>>> hw/rtl/pn2d_pkg.sv
`timescale 1ns / 1ps
package pn2d_pkg;
  localparam int TableSize = 256;
  localparam int IdxBits = 8;
  localparam int FracBits = 16;
  localparam int CoordBits = 24;
  localparam int OutBits = 18;
  localparam int DotBits = FracBits + 3;
  localparam int FadeBits = FracBits + 1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic [0:0] operation;
    logic [IdxBits-1:0] table_index;
    logic [7:0] table_value;
    logic [CoordBits-1:0] x_coord;
    logic [CoordBits-1:0] y_coord;
  } in_word_t;

  typedef struct packed {
    logic signed [OutBits-1:0] noise_value;
  } out_word_t;

  function automatic logic signed [DotBits-1:0] grad_dot(
    input logic [1:0] h,
    input logic signed [DotBits-1:0] dx,
    input logic signed [DotBits-1:0] dy
  );
    logic signed [DotBits-1:0] r;
    case (h)
      2'd0: r = dx + dy;
      2'd1: r = dy - dx;
      2'd2: r = -dx - dy;
      default: r = dx - dy;
    endcase
    return r;
  endfunction
endpackage

>>> hw/rtl/pn2d_stream_if.sv
`timescale 1ns / 1ps
interface pn2d_stream_if #(type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/perlin_noise_2d.sv
`timescale 1ns / 1ps
// Two-dimensional gradient noise, one word per clock unless stalled. A load word
// writes one permutation byte and returns nothing; an evaluate word returns one
// signed Q.16 noise value. The pipeline takes a word every cycle unless stalled:
// a stall on the output freezes the whole pipe. The permutation table is held
// in six copies of a simple dual-port RAM: two reads for the x hash and four
// for the corner hashes. Each load writes all copies on the next advancing
// cycle after it is taken. Loads pass in order with evaluations, so a load is
// seen by every later evaluate word and by no earlier one.
module perlin_noise_2d (
  input logic clk,
  input logic rst,
  pn2d_stream_if.sink   in_if,
  pn2d_stream_if.source out_if
);
  localparam int NS = 9;
  localparam int F = pn2d_pkg::FracBits;
  localparam int IB = pn2d_pkg::IdxBits;
  localparam int D = pn2d_pkg::DotBits;

  logic adv;
  logic [NS-1:0] vld;
  logic [NS-1:0] evl;
  logic [F-1:0] xf [3];
  logic [F-1:0] yf [3];
  logic [IB-1:0] xi0, yi1, yi2;
  logic [IB-1:0] hx0, hx1;
  logic [7:0] hbl, hbr, htl, htr;
  logic ld;
  logic [IB-1:0] lidx;
  logic [7:0] lval;
  logic wr_en;
  logic [IB-1:0] wr_idx;
  logic [7:0] wr_val;
  logic wr_go;

  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;
  assign ld = adv && in_if.valid && (in_if.data.operation == 1'(pn2d_pkg::OP_LOAD));
  assign lidx = in_if.data.table_index;
  assign lval = in_if.data.table_value;
  assign wr_go = wr_en && adv;

  // stage 0 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      evl <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_if.valid};
      evl <= {evl[NS-2:0], in_if.valid &&
              (in_if.data.operation == 1'(pn2d_pkg::OP_EVAL))};
    end
  end

  // hold a load until the next advance
  always_ff @(posedge clk) begin
    if (rst) wr_en <= 1'b0;
    else if (adv) wr_en <= ld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      wr_idx <= lidx;
      wr_val <= lval;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xf[0] <= in_if.data.x_coord[F-1:0];
      yf[0] <= in_if.data.y_coord[F-1:0];
      xi0 <= in_if.data.x_coord[F +: IB];
      yi1 <= in_if.data.y_coord[F +: IB];
      yi2 <= yi1;
      for (int i = 1; i < 3; i++) begin
        xf[i] <= xf[i-1];
        yf[i] <= yf[i-1];
      end
    end
  end

  // x hash: RAM reads in stage 1, data at stage 2
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_hx0 (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(xi0), .rdata(hx0));
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_hx1 (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(xi0 + IB'(1)), .rdata(hx1));
  // corner hashes: reads in stage 2, data at stage 3
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_hbl (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(hx0 + yi2), .rdata(hbl));
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_hbr (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(hx1 + yi2), .rdata(hbr));
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_htl (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(hx0 + yi2 + IB'(1)), .rdata(htl));
  pn2d_ram #(.Width(8), .Depth(pn2d_pkg::TableSize)) u_htr (
    .clk, .we(wr_go), .waddr(wr_idx), .wdata(wr_val), .re(adv),
    .raddr(hx1 + yi2 + IB'(1)), .rdata(htr));

  // dot products at stage 3 (data from stage-2 reads)
  logic signed [D-1:0] dx0, dy0, dx1, dy1;
  logic signed [D-1:0] dbl, dbr, dtl, dtr;
  assign dx0 = D'({1'b0, xf[2]});
  assign dy0 = D'({1'b0, yf[2]});
  assign dx1 = dx0 - (D'(1) <<< F);
  assign dy1 = dy0 - (D'(1) <<< F);
  always_ff @(posedge clk) begin
    if (adv) begin
      dbl <= pn2d_pkg::grad_dot(hbl[1:0], dx0, dy0);
      dbr <= pn2d_pkg::grad_dot(hbr[1:0], dx1, dy0);
      dtl <= pn2d_pkg::grad_dot(htl[1:0], dx0, dy1);
      dtr <= pn2d_pkg::grad_dot(htr[1:0], dx1, dy1);
    end
  end

  // fade, two lanes, stages 1..3
  logic [F-1:0] u2, v2, u3, v3;
  logic [F+3:0] ua, va;
  logic [F+3:0] ub, vb;
  logic [2*F+3:0] pu, pv;
  always_ff @(posedge clk) begin
    if (adv) begin
      u2 <= F'((32'(xf[0]) * 32'(xf[0])) >> F);
      v2 <= F'((32'(yf[0]) * 32'(yf[0])) >> F);
      ua <= (F+4)'(15 << F) - (F+4)'(6 * 32'(xf[0]));
      va <= (F+4)'(15 << F) - (F+4)'(6 * 32'(yf[0]));
      u3 <= F'((32'(u2) * 32'(xf[1])) >> F);
      v3 <= F'((32'(v2) * 32'(yf[1])) >> F);
      ub <= (F+4)'(10 << F) - (F+4)'((40'(xf[1]) * 40'(ua)) >> F);
      vb <= (F+4)'(10 << F) - (F+4)'((40'(yf[1]) * 40'(va)) >> F);
      pu <= (2*F+4)'(u3) * (2*F+4)'(ub);
      pv <= (2*F+4)'(v3) * (2*F+4)'(vb);
    end
  end
  logic [F:0] u5, v5;
  assign u5 = (F+1)'(pu >> F);
  assign v5 = (F+1)'(pv >> F);

  // hold fade and dots together (both ready after stage 3)
  logic [F:0] us, vs;
  logic signed [D-1:0] ebl, ebr, etl, etr;
  always_ff @(posedge clk) begin
    if (adv) begin
      ebl <= dbl; ebr <= dbr; etl <= dtl; etr <= dtr;
      us <= u5; vs <= v5;
    end
  end

  // y lerp: multiply then add
  logic signed [D+F+2:0] ml, mr;
  logic signed [D-1:0] fbl, fbr;
  logic [F:0] uh;
  always_ff @(posedge clk) begin
    if (adv) begin
      ml <= $signed({1'b0, vs}) * (D+F+3)'(etl - ebl);
      mr <= $signed({1'b0, vs}) * (D+F+3)'(etr - ebr);
      fbl <= ebl; fbr <= ebr; uh <= us;
    end
  end
  logic signed [D-1:0] l0, l1;
  logic [F:0] uh2;
  always_ff @(posedge clk) begin
    if (adv) begin
      l0 <= fbl + D'(ml >>> F);
      l1 <= fbr + D'(mr >>> F);
      uh2 <= uh;
    end
  end
  // x lerp
  logic signed [D+F+2:0] mx;
  logic signed [D-1:0] l0d;
  always_ff @(posedge clk) begin
    if (adv) begin
      mx <= $signed({1'b0, uh2}) * (D+F+3)'(l1 - l0);
      l0d <= l0;
    end
  end
  logic signed [D-1:0] rs;
  always_ff @(posedge clk) begin
    if (adv) rs <= l0d + D'(mx >>> F);
  end

  logic signed [D-1:0] one_s;
  logic signed [D-1:0] sat;
  assign one_s = D'(1) <<< F;
  always_comb begin
    sat = rs;
    if (rs > one_s) sat = one_s;
    if (rs < -one_s) sat = -one_s;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_if.valid <= 1'b0;
    else if (adv) out_if.valid <= evl[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) out_if.data.noise_value <= pn2d_pkg::OutBits'(sat);
  end

`ifndef SYNTHESIS
  a_evl_in_vld: assert property (@(posedge clk) disable iff (rst)
    (evl & ~vld) == '0) else $error("eval bit without valid");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("pipe moved while stalled");
  a_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_if.valid == $past(evl[NS-1])) else $error("output valid mismatch");
`endif
endmodule

>>> hw/rtl/pn2d_ram.sv
`timescale 1ns / 1ps
module pn2d_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
